// ===== src/esc_pkg.sv =====
`timescale 1ns / 1ps

package esc_pkg;

  // Fixed conversion constants
  localparam logic [31:0] SecsPerDay  = 32'd86400;
  localparam logic [31:0] SecsPerHour = 32'd3600;
  localparam logic [31:0] SecsPerMin  = 32'd60;
  localparam logic [11:0] EpochYear   = 12'd1970;
  // 1970-01-01 is a Thursday: offset 3 from Monday
  localparam logic [2:0]  EpochWday   = 3'd3;
  localparam logic [8:0]  DaysLeap    = 9'd366;
  localparam logic [8:0]  DaysCommon  = 9'd365;
  localparam logic [3:0]  MonthDec    = 4'd12;

  // Rounded-up reciprocals for the odd part of each divisor.
  // 86400 = 675 << 7, 3600 = 225 << 4, 60 = 15 << 2.
  localparam logic [25:0] DayRecip  = 26'd50903317;  // ceil(2^35 / 675), 25-bit operand
  localparam logic [13:0] HourRecip = 14'd9321;      // ceil(2^21 / 225), 13-bit operand
  localparam logic [10:0] MinRecip  = 11'd1093;      // ceil(2^14 / 15), 10-bit operand

  // Controller to datapath commands
  typedef struct packed {
    logic load_day;
    logic load_hour;
    logic load_min;
    logic div_day;
    logic div_hour;
    logic div_min;
    logic load_sec;
    logic year_step;
    logic month_step;
    logic finish;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic year_done;
    logic month_done;
  } status_t;

  // Reachable years are 1970..2106; 2000 is the only /400 year and
  // 2100 the only other century year in that span.
  function automatic logic leap_year(input logic [11:0] y);
    return (y[1:0] == 2'b00) && (y != 12'd2100);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    unique case (m)
      4'd1:    len = 5'd31;
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd3:    len = 5'd31;
      4'd4:    len = 5'd30;
      4'd5:    len = 5'd31;
      4'd6:    len = 5'd30;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd31;
      4'd9:    len = 5'd30;
      4'd10:   len = 5'd31;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== src/esc_ctrl.sv =====
`timescale 1ns / 1ps

module esc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  esc_pkg::status_t  status_i,
  output esc_pkg::cmd_t     cmd_o,
  output logic              busy,
  output logic              valid_o
);

  typedef enum logic [8:0] {
    StIdle    = 9'b000000001,
    StDayDiv  = 9'b000000010,
    StHourLd  = 9'b000000100,
    StHourDiv = 9'b000001000,
    StMinLd   = 9'b000010000,
    StMinDiv  = 9'b000100000,
    StYear    = 9'b001000000,
    StMonth   = 9'b010000000,
    StDone    = 9'b100000000
  } state_e;

  state_e     state_q, state_d;
  logic       valid_q, valid_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    valid_d = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          cmd_o.load_day = 1'b1;
          state_d        = StDayDiv;
        end
      end
      StDayDiv: begin
        cmd_o.div_day = 1'b1;
        state_d       = StHourLd;
      end
      StHourLd: begin
        cmd_o.load_hour = 1'b1;
        state_d         = StHourDiv;
      end
      StHourDiv: begin
        cmd_o.div_hour = 1'b1;
        state_d        = StMinLd;
      end
      StMinLd: begin
        cmd_o.load_min = 1'b1;
        state_d        = StMinDiv;
      end
      StMinDiv: begin
        cmd_o.div_min = 1'b1;
        state_d       = StYear;
      end
      StYear: begin
        cmd_o.load_sec = 1'b1;
        if (status_i.year_done) state_d = StMonth;
        else                    cmd_o.year_step = 1'b1;
      end
      StMonth: begin
        if (status_i.month_done) state_d = StDone;
        else                     cmd_o.month_step = 1'b1;
      end
      StDone: begin
        cmd_o.finish = 1'b1;
        valid_d      = 1'b1;
        state_d      = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  assign busy    = (state_q != StIdle);
  assign valid_o = valid_q;

endmodule

// ===== src/esc_dp.sv =====
`timescale 1ns / 1ps

module esc_dp (
  input  logic              clk_i,
  input  esc_pkg::cmd_t     cmd_i,
  input  logic [31:0]       unix_secs_i,
  output esc_pkg::status_t  status_o,
  output logic [11:0]       year_o,
  output logic [3:0]        month_o,
  output logic [4:0]        day_o,
  output logic [2:0]        weekday_o,
  output logic [4:0]        hour_o,
  output logic [5:0]        minute_o,
  output logic [5:0]        second_o
);

  // Seconds split: running remainder and last quotient
  logic [31:0] rem_q, rem_d;
  logic [15:0] quo_q, quo_d;
  // Calendar walk
  logic [15:0] days_q, days_d;
  logic [11:0] yr_q, yr_d;
  logic [3:0]  mon_q, mon_d;
  logic [2:0]  wk_q, wk_d;
  logic [4:0]  hr_q, hr_d;
  logic [5:0]  mn_q, mn_d;
  logic [5:0]  sc_q, sc_d;
  // Result registers
  logic [11:0] year_q;
  logic [3:0]  month_q;
  logic [4:0]  day_q;
  logic [2:0]  weekday_q;
  logic [4:0]  hour_q;
  logic [5:0]  minute_q;
  logic [5:0]  second_q;

  logic [50:0] day_prod;
  logic [26:0] hour_prod;
  logic [20:0] min_prod;
  logic [31:0] tod;
  logic [31:0] min_left;
  logic [31:0] sec_left;
  logic        leap;
  logic [8:0]  ylen;
  logic [4:0]  mlen;
  logic [3:0]  wk_sum;
  logic [2:0]  wk_inc;
  logic [5:0]  wd_v0, wd_v1, wd_v2, wd_v3;

  // Quotients: drop the power-of-two part of the divisor, then multiply-high
  // by the rounded-up reciprocal of the odd part (exact over each operand range)
  assign day_prod  = 51'(rem_q[31:7]) * 51'(esc_pkg::DayRecip);
  assign hour_prod = 27'(rem_q[16:4]) * 27'(esc_pkg::HourRecip);
  assign min_prod  = 21'(rem_q[11:2]) * 21'(esc_pkg::MinRecip);

  // Remainders from the registered quotient
  assign tod      = rem_q - 32'(quo_q) * esc_pkg::SecsPerDay;
  assign min_left = rem_q - 32'(quo_q) * esc_pkg::SecsPerHour;
  assign sec_left = rem_q - 32'(quo_q) * esc_pkg::SecsPerMin;

  // Year and month lengths
  assign leap = esc_pkg::leap_year(yr_q);
  assign ylen = leap ? esc_pkg::DaysLeap : esc_pkg::DaysCommon;
  assign mlen = esc_pkg::month_len(mon_q, leap);

  assign status_o.year_done  = (days_q < {7'd0, ylen});
  assign status_o.month_done = (mon_q == esc_pkg::MonthDec) || (days_q < {11'd0, mlen});

  // Weekday offset advance, mod 7; a year moves it by 1 or 2, a month by len-28
  assign wk_inc = cmd_i.year_step ? (leap ? 3'd2 : 3'd1) : (mlen[2:0] - 3'd4);
  assign wk_sum = {1'b0, wk_q} + {1'b0, wk_inc};

  // Final weekday: (offset + days left) mod 7, sum is at most 36
  assign wd_v0 = {3'd0, wk_q} + {1'b0, days_q[4:0]};
  assign wd_v1 = (wd_v0 >= 6'd28) ? wd_v0 - 6'd28 : wd_v0;
  assign wd_v2 = (wd_v1 >= 6'd14) ? wd_v1 - 6'd14 : wd_v1;
  assign wd_v3 = (wd_v2 >= 6'd7)  ? wd_v2 - 6'd7  : wd_v2;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    days_d = days_q;
    yr_d   = yr_q;
    mon_d  = mon_q;
    wk_d   = wk_q;
    hr_d   = hr_q;
    mn_d   = mn_q;
    sc_d   = sc_q;

    if (cmd_i.load_day) begin
      rem_d = unix_secs_i;
    end
    if (cmd_i.div_day) begin
      quo_d = day_prod[50:35];
    end
    // Day count done: keep time of day and start the calendar walk
    if (cmd_i.load_hour) begin
      days_d = quo_q;
      rem_d  = tod;
      yr_d   = esc_pkg::EpochYear;
      mon_d  = 4'd1;
      wk_d   = esc_pkg::EpochWday;
    end
    if (cmd_i.div_hour) begin
      quo_d = {10'd0, hour_prod[26:21]};
    end
    if (cmd_i.load_min) begin
      hr_d  = quo_q[4:0];
      rem_d = min_left;
    end
    if (cmd_i.div_min) begin
      quo_d = {9'd0, min_prod[20:14]};
    end
    if (cmd_i.load_sec) begin
      mn_d = quo_q[5:0];
      sc_d = sec_left[5:0];
    end
    if (cmd_i.year_step) begin
      days_d = days_q - {7'd0, ylen};
      yr_d   = yr_q + 12'd1;
    end
    if (cmd_i.month_step) begin
      days_d = days_q - {11'd0, mlen};
      mon_d  = mon_q + 4'd1;
    end
    if (cmd_i.year_step || cmd_i.month_step) begin
      wk_d = (wk_sum >= 4'd7) ? 3'(wk_sum - 4'd7) : wk_sum[2:0];
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    days_q <= days_d;
    yr_q   <= yr_d;
    mon_q  <= mon_d;
    wk_q   <= wk_d;
    hr_q   <= hr_d;
    mn_q   <= mn_d;
    sc_q   <= sc_d;
  end

  // Result capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      year_q    <= yr_q;
      month_q   <= mon_q;
      day_q     <= days_q[4:0] + 5'd1;
      weekday_q <= wd_v3[2:0] + 3'd1;
      hour_q    <= hr_q;
      minute_q  <= mn_q;
      second_q  <= sc_q;
    end
  end

  assign year_o    = year_q;
  assign month_o   = month_q;
  assign day_o     = day_q;
  assign weekday_o = weekday_q;
  assign hour_o    = hour_q;
  assign minute_o  = minute_q;
  assign second_o  = second_q;

endmodule

// ===== src/epoch_seconds_to_calendar_core.sv =====
`timescale 1ns / 1ps

// Channel   Handshake            Payload
// input     start, busy          unix_secs_i
// result    valid_o (strobe)     year_o month_o day_o weekday_o hour_o minute_o second_o
//
// From start to the result strobe the controller steps through the day, hour and minute
// loads and divides, then once per whole year after 1970 (0..136) and once per whole
// month (0..11). Reciprocal-multiply steps split the seconds into days, hours, minutes
// and seconds; the one-per-cycle year and month walk sets the rest. busy is high from
// acceptance until the strobe cycle; the result strobe is high for a single cycle and
// the receiver cannot stall it. Reset only clears the controller.

module epoch_seconds_to_calendar_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] unix_secs_i,
  output logic        valid_o,
  output logic [11:0] year_o,
  output logic [3:0]  month_o,
  output logic [4:0]  day_o,
  output logic [2:0]  weekday_o,
  output logic [4:0]  hour_o,
  output logic [5:0]  minute_o,
  output logic [5:0]  second_o
);

  esc_pkg::cmd_t    cmd;
  esc_pkg::status_t status;

  esc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy),
    .valid_o  (valid_o)
  );

  esc_dp u_dp (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .unix_secs_i (unix_secs_i),
    .status_o    (status),
    .year_o      (year_o),
    .month_o     (month_o),
    .day_o       (day_o),
    .weekday_o   (weekday_o),
    .hour_o      (hour_o),
    .minute_o    (minute_o),
    .second_o    (second_o)
  );

endmodule

// ===== src/esc_checker.sv =====
`timescale 1ns / 1ps

module esc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       valid_o,
  input logic [3:0] month_o,
  input logic [4:0] day_o,
  input logic [2:0] weekday_o,
  input logic [4:0] hour_o
);

  // Accepted item makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("busy not raised after accept");

  // Result strobe appears exactly when busy drops
  a_fall_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> valid_o) else $error("busy dropped without a result");

  a_valid_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy && $past(busy)) else $error("result strobe out of place");

  a_valid_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o) else $error("result strobe longer than one cycle");

  // Result fields in range
  a_ranges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> month_o >= 4'd1 && month_o <= 4'd12 && day_o >= 5'd1 &&
                weekday_o >= 3'd1 && weekday_o <= 3'd7 && hour_o <= 5'd23)
    else $error("result field out of range");

endmodule

bind epoch_seconds_to_calendar_core esc_checker u_esc_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .start     (start),
  .busy      (busy),
  .valid_o   (valid_o),
  .month_o   (month_o),
  .day_o     (day_o),
  .weekday_o (weekday_o),
  .hour_o    (hour_o)
);
